### rtl/core/gqi_pkg.sv
// Shared types, constants and lookup functions for the gyro quaternion integrator.
package gqi_pkg;

    localparam int QUAT_WIDTH = 32;
    localparam logic [32:0] DEG_TO_RAD_Q32 = 33'd74961321;
    localparam logic signed [36:0] LIM31_POS = 37'sd2147483647;
    localparam logic signed [36:0] LIM31_NEG = -37'sd2147483647;
    localparam logic [30:0] SAT_MAG = 31'h7fffffff;
    localparam logic [31:0] HALF_TICK_RESET = 32'd2147484;
    localparam logic signed [31:0] ONE_Q30 = 32'sh40000000;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_H,
        OP_HCAP,
        OP_MK,
        OP_MKCAP,
        OP_PP,
        OP_PPACC,
        OP_ANG,
        OP_TERM,
        OP_TERMACC,
        OP_SUM,
        OP_SCALE,
        OP_SQ,
        OP_SQACC,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_DIVINIT,
        OP_DIVSTEP,
        OP_DIVDONE,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] idx;
        logic [1:0] sub;
    } cmd_t;

    typedef struct packed {
        logic prev_zero;
        logic big;
        logic norm_zero;
        logic out_full;
    } status_t;

    // Which stored component multiplies the half angle of axis "term" in sum "comp".
    function automatic logic [1:0] term_qsel(input logic [1:0] comp, input logic [1:0] term);
        logic [1:0] r;
        r = 2'd0;
        case ({comp, term})
            4'b0000: r = 2'd1;
            4'b0001: r = 2'd2;
            4'b0010: r = 2'd3;
            4'b0100: r = 2'd0;
            4'b0101: r = 2'd3;
            4'b0110: r = 2'd2;
            4'b1000: r = 2'd3;
            4'b1001: r = 2'd0;
            4'b1010: r = 2'd1;
            4'b1100: r = 2'd2;
            4'b1101: r = 2'd1;
            4'b1110: r = 2'd0;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // Sign of that product in the quaternion derivative.
    function automatic logic term_neg(input logic [1:0] comp, input logic [1:0] term);
        logic r;
        r = 1'b0;
        case ({comp, term})
            4'b0000: r = 1'b1;
            4'b0001: r = 1'b1;
            4'b0010: r = 1'b1;
            4'b0101: r = 1'b1;
            4'b1010: r = 1'b1;
            4'b1100: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

### rtl/core/gyro_quaternion_integrator.sv
// Top level of the gyro quaternion integrator.
// Each accepted sample (timestamp and three body rates in deg/s) advances a Q2.30 attitude
// quaternion by one first-order step and renormalizes it; the sample that arrives while the
// stored time is zero only records its time and gives no result. For a sample that produces a
// result, a shared 33x33 multiplier forms the step length, the three half angles, the derivative
// terms and the squares for the norm, a bit-serial root takes the norm, and a radix-2 divider
// produces each of the four components in turn. When the norm is zero the division is skipped.
// When a derivative sum is out of range, all four sums are halved until they fit. A new sample
// is taken as soon as the previous one is done, even while its result still waits in the output
// register.
module gyro_quaternion_integrator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [31:0]                       cfg_data,   // half_tick_seconds
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [127:0]                      s_tdata,    // timestamp, rate_x, rate_y, rate_z
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [4*gqi_pkg::QUAT_WIDTH-1:0]  m_tdata     // quat_w, quat_x, quat_y, quat_z
);

    gqi_pkg::cmd_t    cmd;
    gqi_pkg::status_t status;

    assign cfg_ready = 1'b1;

    gqi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gqi_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

### rtl/core/gqi_datapath.sv
// Datapath: shared multiplier, accumulators, square root and divider, attitude storage.
module gqi_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gqi_pkg::cmd_t                 cmd,
    output gqi_pkg::status_t              status,
    input  logic                          cfg_valid,
    input  logic [31:0]                   cfg_data,
    input  logic [127:0]                  s_tdata,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [4*gqi_pkg::QUAT_WIDTH-1:0] m_tdata
);

    logic [31:0]        hts_reg;
    logic [31:0]        prev_reg;
    logic [31:0]        ticks_reg;
    logic signed [31:0] rate_reg [3];
    logic [63:0]        h_reg;
    logic [58:0]        m_reg;
    logic [122:0]       acc_reg;
    logic signed [31:0] ang_reg [3];
    logic signed [31:0] q_reg [4];
    logic signed [65:0] sum_reg;
    logic signed [36:0] s_reg [4];
    logic [63:0]        sumsq_reg;
    logic [63:0]        v_reg;
    logic [63:0]        res_reg;
    logic [63:0]        bit_reg;
    logic [31:0]        rem_reg;
    logic [31:0]        low_reg;
    logic [31:0]        quot_reg;
    logic signed [65:0] p_reg;
    logic               out_valid_reg;
    logic signed [31:0] out_q_reg [4];

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic [1:0]         q_addr;
    logic signed [31:0] q_rd;
    logic signed [31:0] ang_rd;
    logic signed [31:0] rate_rd;
    logic signed [36:0] s_rd;
    logic [31:0]        rate_mag;
    logic [31:0]        norm;
    logic               big;
    logic [122:0]       pp_add;
    logic [30:0]        ang_mag;
    logic signed [65:0] term_add;
    logic signed [65:0] rnd;
    logic [36:0]        s_mag;
    logic [63:0]        num;
    logic [63:0]        sq_try;
    logic [32:0]        div_try;
    logic [31:0]        q_sat;

    assign q_addr  = (cmd.op == gqi_pkg::OP_TERM) ? gqi_pkg::term_qsel(cmd.idx, cmd.sub)
                                                  : cmd.idx;
    assign q_rd    = q_reg[q_addr];
    assign ang_rd  = ang_reg[cmd.sub];
    assign rate_rd = rate_reg[cmd.idx];
    assign s_rd    = s_reg[cmd.idx];
    assign rate_mag = rate_rd[31] ? 32'(-rate_rd) : 32'(rate_rd);
    assign norm    = res_reg[31:0];

    always_comb
    begin
        big = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            if (s_reg[i] > gqi_pkg::LIM31_POS || s_reg[i] < gqi_pkg::LIM31_NEG)
            begin
                big = 1'b1;
            end
        end
    end

    assign status.prev_zero = (prev_reg == 32'd0);
    assign status.big       = big;
    assign status.norm_zero = (norm == 32'd0);
    assign status.out_full  = out_valid_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            gqi_pkg::OP_H:
            begin
                mul_a = {1'b0, hts_reg};
                mul_b = {1'b0, ticks_reg};
            end
            gqi_pkg::OP_MK:
            begin
                mul_a = {1'b0, rate_mag};
                mul_b = gqi_pkg::DEG_TO_RAD_Q32;
            end
            gqi_pkg::OP_PP:
            begin
                mul_a = cmd.sub[1] ? {6'd0, m_reg[58:32]} : {1'b0, m_reg[31:0]};
                mul_b = cmd.sub[0] ? {1'b0, h_reg[63:32]} : {1'b0, h_reg[31:0]};
            end
            gqi_pkg::OP_TERM:
            begin
                mul_a = {q_rd[31], q_rd};
                mul_b = {ang_rd[31], ang_rd};
            end
            gqi_pkg::OP_SQ:
            begin
                mul_a = s_rd[32:0];
                mul_b = s_rd[32:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Partial products of the half-angle multiply land at 0, 32 or 64 bits.
    always_comb
    begin
        case (cmd.sub)
            2'd0:    pp_add = 123'(p_reg[63:0]);
            2'd3:    pp_add = 123'(p_reg[63:0]) << 64;
            default: pp_add = 123'(p_reg[63:0]) << 32;
        endcase
    end

    assign ang_mag  = (|acc_reg[122:81]) ? gqi_pkg::SAT_MAG : acc_reg[80:50];
    assign term_add = gqi_pkg::term_neg(cmd.idx, cmd.sub) ? -p_reg : p_reg;
    assign rnd      = (sum_reg + 66'sd536870912) >>> 30;
    assign s_mag    = s_rd[36] ? 37'(-s_rd) : 37'(s_rd);
    assign num      = {2'b00, s_mag[31:0], 30'd0} + 64'(norm >> 1);
    assign sq_try   = res_reg + bit_reg;
    assign div_try  = {rem_reg, low_reg[31]};
    assign q_sat    = (quot_reg > 32'(gqi_pkg::SAT_MAG)) ? 32'(gqi_pkg::SAT_MAG) : quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hts_reg       <= gqi_pkg::HALF_TICK_RESET;
            prev_reg      <= 32'd0;
            q_reg[0]      <= gqi_pkg::ONE_Q30;
            q_reg[1]      <= 32'sd0;
            q_reg[2]      <= 32'sd0;
            q_reg[3]      <= 32'sd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                hts_reg <= cfg_data;
            end
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                gqi_pkg::OP_LOAD:
                begin
                    prev_reg    <= s_tdata[31:0];
                    ticks_reg   <= s_tdata[31:0] - prev_reg;
                    rate_reg[0] <= s_tdata[63:32];
                    rate_reg[1] <= s_tdata[95:64];
                    rate_reg[2] <= s_tdata[127:96];
                end
                gqi_pkg::OP_HCAP:
                begin
                    h_reg <= p_reg[63:0];
                end
                gqi_pkg::OP_MKCAP:
                begin
                    m_reg   <= p_reg[58:0];
                    acc_reg <= 123'd1 << 49;
                end
                gqi_pkg::OP_PPACC:
                begin
                    acc_reg <= acc_reg + pp_add;
                end
                gqi_pkg::OP_ANG:
                begin
                    ang_reg[cmd.idx] <= rate_rd[31] ? -{1'b0, ang_mag} : {1'b0, ang_mag};
                end
                gqi_pkg::OP_TERMACC:
                begin
                    sum_reg <= (cmd.sub == 2'd0) ? term_add : sum_reg + term_add;
                end
                gqi_pkg::OP_SUM:
                begin
                    s_reg[cmd.idx] <= 37'(q_rd) + rnd[36:0];
                end
                gqi_pkg::OP_SCALE:
                begin
                    if (big)
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            s_reg[i] <= s_reg[i] >>> 1;
                        end
                    end
                end
                gqi_pkg::OP_SQACC:
                begin
                    sumsq_reg <= ((cmd.idx == 2'd0) ? 64'd0 : sumsq_reg) + p_reg[63:0];
                end
                gqi_pkg::OP_SQRT_INIT:
                begin
                    v_reg   <= sumsq_reg;
                    res_reg <= 64'd0;
                    bit_reg <= 64'd1 << 62;
                end
                gqi_pkg::OP_SQRT_STEP:
                begin
                    if (v_reg >= sq_try)
                    begin
                        v_reg   <= v_reg - sq_try;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
                gqi_pkg::OP_DIVINIT:
                begin
                    rem_reg  <= num[63:32];
                    low_reg  <= num[31:0];
                    quot_reg <= 32'd0;
                end
                gqi_pkg::OP_DIVSTEP:
                begin
                    low_reg <= {low_reg[30:0], 1'b0};
                    if (div_try >= {1'b0, norm})
                    begin
                        rem_reg  <= 32'(div_try - {1'b0, norm});
                        quot_reg <= {quot_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= div_try[31:0];
                        quot_reg <= {quot_reg[30:0], 1'b0};
                    end
                end
                gqi_pkg::OP_DIVDONE:
                begin
                    q_reg[cmd.idx] <= s_rd[36] ? -q_sat : q_sat;
                end
                gqi_pkg::OP_EMIT:
                begin
                    out_valid_reg <= 1'b1;
                    for (int i = 0; i < 4; i++)
                    begin
                        out_q_reg[i] <= q_reg[i];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= mul_a * mul_b;
    end

    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            m_tdata[i*gqi_pkg::QUAT_WIDTH +: gqi_pkg::QUAT_WIDTH] =
                gqi_pkg::QUAT_WIDTH'(out_q_reg[i]);
        end
    end

endmodule

### rtl/core/gqi_ctrl.sv
// Controller: sequences the datapath through one integration step per sample.
module gqi_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  gqi_pkg::status_t status,
    output gqi_pkg::cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_H,
        ST_HCAP,
        ST_MK,
        ST_MKCAP,
        ST_PP,
        ST_PPACC,
        ST_ANG,
        ST_TERM,
        ST_TERMACC,
        ST_SUM,
        ST_SCALE,
        ST_SQ,
        ST_SQACC,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_NCHK,
        ST_DIVINIT,
        ST_DIV,
        ST_DIVDONE,
        ST_EMIT
    } state_t;

    state_t     state_reg;
    logic [1:0] idx_reg;
    logic [1:0] sub_reg;
    logic [4:0] step_reg;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd.idx = idx_reg;
        cmd.sub = sub_reg;
        case (state_reg)
            ST_IDLE:      cmd.op = s_tvalid ? gqi_pkg::OP_LOAD : gqi_pkg::OP_NONE;
            ST_H:         cmd.op = gqi_pkg::OP_H;
            ST_HCAP:      cmd.op = gqi_pkg::OP_HCAP;
            ST_MK:        cmd.op = gqi_pkg::OP_MK;
            ST_MKCAP:     cmd.op = gqi_pkg::OP_MKCAP;
            ST_PP:        cmd.op = gqi_pkg::OP_PP;
            ST_PPACC:     cmd.op = gqi_pkg::OP_PPACC;
            ST_ANG:       cmd.op = gqi_pkg::OP_ANG;
            ST_TERM:      cmd.op = gqi_pkg::OP_TERM;
            ST_TERMACC:   cmd.op = gqi_pkg::OP_TERMACC;
            ST_SUM:       cmd.op = gqi_pkg::OP_SUM;
            ST_SCALE:     cmd.op = gqi_pkg::OP_SCALE;
            ST_SQ:        cmd.op = gqi_pkg::OP_SQ;
            ST_SQACC:     cmd.op = gqi_pkg::OP_SQACC;
            ST_SQRT_INIT: cmd.op = gqi_pkg::OP_SQRT_INIT;
            ST_SQRT:      cmd.op = gqi_pkg::OP_SQRT_STEP;
            ST_DIVINIT:   cmd.op = gqi_pkg::OP_DIVINIT;
            ST_DIV:       cmd.op = gqi_pkg::OP_DIVSTEP;
            ST_DIVDONE:   cmd.op = gqi_pkg::OP_DIVDONE;
            ST_EMIT:      cmd.op = status.out_full ? gqi_pkg::OP_NONE : gqi_pkg::OP_EMIT;
            default:      cmd.op = gqi_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= 2'd0;
            sub_reg   <= 2'd0;
            step_reg  <= 5'd0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    // The very first sample only records its time.
                    if (s_tvalid && !status.prev_zero)
                    begin
                        state_reg <= ST_H;
                    end
                end
                ST_H:
                begin
                    state_reg <= ST_HCAP;
                end
                ST_HCAP:
                begin
                    idx_reg   <= 2'd0;
                    state_reg <= ST_MK;
                end
                ST_MK:
                begin
                    state_reg <= ST_MKCAP;
                end
                ST_MKCAP:
                begin
                    sub_reg   <= 2'd0;
                    state_reg <= ST_PP;
                end
                ST_PP:
                begin
                    state_reg <= ST_PPACC;
                end
                ST_PPACC:
                begin
                    sub_reg   <= sub_reg + 2'd1;
                    state_reg <= (sub_reg == 2'd3) ? ST_ANG : ST_PP;
                end
                ST_ANG:
                begin
                    if (idx_reg == 2'd2)
                    begin
                        idx_reg   <= 2'd0;
                        sub_reg   <= 2'd0;
                        state_reg <= ST_TERM;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= ST_MK;
                    end
                end
                ST_TERM:
                begin
                    state_reg <= ST_TERMACC;
                end
                ST_TERMACC:
                begin
                    if (sub_reg == 2'd2)
                    begin
                        state_reg <= ST_SUM;
                    end
                    else
                    begin
                        sub_reg   <= sub_reg + 2'd1;
                        state_reg <= ST_TERM;
                    end
                end
                ST_SUM:
                begin
                    sub_reg <= 2'd0;
                    if (idx_reg == 2'd3)
                    begin
                        state_reg <= ST_SCALE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= ST_TERM;
                    end
                end
                ST_SCALE:
                begin
                    // Halve all four sums until every one fits in Q2.30.
                    if (!status.big)
                    begin
                        idx_reg   <= 2'd0;
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ:
                begin
                    state_reg <= ST_SQACC;
                end
                ST_SQACC:
                begin
                    if (idx_reg == 2'd3)
                    begin
                        state_reg <= ST_SQRT_INIT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQRT_INIT:
                begin
                    step_reg  <= 5'd0;
                    state_reg <= ST_SQRT;
                end
                ST_SQRT:
                begin
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd31)
                    begin
                        state_reg <= ST_NCHK;
                    end
                end
                ST_NCHK:
                begin
                    idx_reg   <= 2'd0;
                    state_reg <= status.norm_zero ? ST_EMIT : ST_DIVINIT;
                end
                ST_DIVINIT:
                begin
                    step_reg  <= 5'd0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd31)
                    begin
                        state_reg <= ST_DIVDONE;
                    end
                end
                ST_DIVDONE:
                begin
                    if (idx_reg == 2'd3)
                    begin
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= ST_DIVINIT;
                    end
                end
                ST_EMIT:
                begin
                    if (!status.out_full)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
